### hdl/psx_pkg.sv
// Shared types, constants and codes for the Philox-seeded xoshiro256++ uniform generator.
// No dependencies; imported by the front, seed unit, back end, top level and testbench.
package psx_pkg;

    localparam int SUBCHUNK_LEN  = 512;
    localparam int POS_W         = $clog2(SUBCHUNK_LEN);
    localparam int PHILOX_ROUNDS = 10;
    localparam int ROUND_W       = $clog2(PHILOX_ROUNDS + 1);

    localparam logic [63:0] KEY_LOW_RESET  = 64'h243f6a8885a308d3;
    localparam logic [63:0] KEY_HIGH_RESET = 64'h13198a2e03707344;
    localparam logic [63:0] PX_MUL0        = 64'hD2E7470EE14C6C93;
    localparam logic [63:0] PX_MUL1        = 64'hCA5A826395121157;
    localparam logic [63:0] PX_BUMP0       = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] PX_BUMP1       = 64'hBB67AE8584CAA73B;
    localparam logic [10:0] EXP_BASE       = 11'd970;

    // Phases of one Philox round: four partial products, four accumulates, one update
    localparam logic [3:0] PHASE_UPDATE = 4'd8;

    localparam logic CMD_NEXT = 1'b0;
    localparam logic CMD_SEEK = 1'b1;

    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic        command;
        logic [63:0] seek_subchunk;
    } item_t;

    typedef struct packed {
        logic        start;
        logic [63:0] counter;
        logic [63:0] key_low;
        logic [63:0] key_high;
    } seed_req_t;

    typedef struct packed {
        logic            done;
        logic [3:0][63:0] words;
    } seed_rsp_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SEED_START,
        B_SEED_WAIT,
        B_GEN,
        B_CONV,
        B_PACK
    } back_state_t;

    typedef struct packed {
        logic pop;
        logic seed_start;
        logic load_seed;
        logic gen;
        logic conv;
        logic pack;
    } back_ctl_t;

endpackage

### hdl/psx_if.sv
// Channel interfaces: input items, result items and configuration writes.
// Depends on nothing; used by the front, back and top-level modules.
interface psx_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [63:0] seek_subchunk;
    modport source (output valid, command, seek_subchunk, input ready);
    modport sink   (input valid, command, seek_subchunk, output ready);
endinterface

interface psx_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] raw_word;
    logic [63:0] uniform_bits;
    logic [52:0] uniform_fraction;
    logic        last_of_subchunk;
    modport source (output valid, raw_word, uniform_bits, uniform_fraction, last_of_subchunk,
                    input ready);
    modport sink   (input valid, raw_word, uniform_bits, uniform_fraction, last_of_subchunk,
                    output ready);
endinterface

interface psx_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/psx_front.sv
// Front end: accepts input transactions and holds them in a two-entry queue.
// Depends on psx_pkg and psx_in_if.
module psx_front (
    input  logic             clk,
    input  logic             rst_n,
    psx_in_if.sink           in_ch,
    input  logic             pop,
    output logic             q_valid,
    output psx_pkg::item_t   q_item
);
    import psx_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        do_pop;

    assign in_ch.ready = (count_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (count_reg != 2'd0);
    assign do_pop      = pop && q_valid;
    assign q_item      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{command: in_ch.command,
                                      seek_subchunk: in_ch.seek_subchunk};
        end
    end

endmodule

### hdl/psx_philox.sv
// Philox4x64 seed unit: one 32x32 multiplier per product; each round runs partial products, accumulates and an update.
// Depends on psx_pkg.
module psx_philox (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psx_pkg::seed_req_t    req,
    output psx_pkg::seed_rsp_t    rsp
);
    import psx_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [3:0]         phase_reg;
    logic [ROUND_W-1:0] round_reg;
    logic [63:0]        c0_reg, c1_reg, c2_reg, c3_reg;
    logic [63:0]        k0_reg, k1_reg;
    logic [63:0]        prod0_reg, prod1_reg;
    logic [127:0]       acc0_reg, acc1_reg;
    logic [127:0]       acc0_next, acc1_next;
    logic [1:0]         part;
    logic [31:0]        a0, a1, b0, b1;
    logic [7:0]         shift;
    logic               last_round;

    assign part       = phase_reg[2:1];
    assign a0         = part[1] ? PX_MUL0[63:32] : PX_MUL0[31:0];
    assign a1         = part[1] ? PX_MUL1[63:32] : PX_MUL1[31:0];
    assign b0         = part[0] ? c0_reg[63:32] : c0_reg[31:0];
    assign b1         = part[0] ? c2_reg[63:32] : c2_reg[31:0];
    assign shift      = {1'b0, ({1'b0, part[1]} + {1'b0, part[0]}), 5'd0};
    assign acc0_next  = acc0_reg + ({64'd0, prod0_reg} << shift);
    assign acc1_next  = acc1_reg + ({64'd0, prod1_reg} << shift);
    assign last_round = (round_reg == ROUND_W'(PHILOX_ROUNDS - 1));

    assign rsp.done  = done_reg;
    assign rsp.words = {c3_reg, c2_reg, c1_reg, c0_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 4'd0;
            round_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 4'd0;
                round_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (phase_reg == PHASE_UPDATE)
                begin
                    phase_reg <= 4'd0;
                    round_reg <= round_reg + 1'b1;
                    if (last_round)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
                else
                begin
                    phase_reg <= phase_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            c0_reg   <= req.counter;
            c1_reg   <= 64'd0;
            c2_reg   <= 64'd1;
            c3_reg   <= 64'd1;
            k0_reg   <= req.key_low;
            k1_reg   <= req.key_high;
            acc0_reg <= '0;
            acc1_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (phase_reg == PHASE_UPDATE)
            begin
                // Round function, then bump the key for the next round
                c0_reg   <= acc1_reg[127:64] ^ c1_reg ^ k0_reg;
                c1_reg   <= acc1_reg[63:0];
                c2_reg   <= acc0_reg[127:64] ^ c3_reg ^ k1_reg;
                c3_reg   <= acc0_reg[63:0];
                k0_reg   <= k0_reg + PX_BUMP0;
                k1_reg   <= k1_reg + PX_BUMP1;
                acc0_reg <= '0;
                acc1_reg <= '0;
            end
            else if (!phase_reg[0])
            begin
                prod0_reg <= a0 * b0;
                prod1_reg <= a1 * b1;
            end
            else
            begin
                acc0_reg <= acc0_next;
                acc1_reg <= acc1_next;
            end
        end
    end

endmodule

### hdl/psx_back.sv
// Back end: sequencer, xoshiro256++ state, double conversion and result register.
// Depends on psx_pkg and psx_out_if; drives the seed unit through seed_req_t.
module psx_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  psx_pkg::item_t        q_item,
    output logic                  pop,
    input  logic [63:0]           key_low,
    input  logic [63:0]           key_high,
    output psx_pkg::seed_req_t    seed_req,
    input  psx_pkg::seed_rsp_t    seed_rsp,
    psx_out_if.source             out_ch
);
    import psx_pkg::*;

    back_state_t      state_reg, state_next;
    back_ctl_t        ctl;
    logic [63:0]      wa_reg, wb_reg, wc_reg, wd_reg;
    logic [63:0]      subchunk_reg;
    logic [POS_W-1:0] pos_reg;
    logic [63:0]      r_reg;
    logic             last_reg;
    logic [5:0]       p_reg;
    logic             out_valid_reg;
    logic [63:0]      out_raw_reg, out_bits_reg;
    logic [52:0]      out_frac_reg;
    logic             out_last_reg;
    logic [63:0]      sum, rot, r_next, t, wc1, wd1, wb1, wa1;
    logic [52:0]      v, v_reg_frac, v_shift;
    logic [5:0]       p_next;
    logic             seed_zero;
    logic             is_last;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    if (q_item.command == CMD_SEEK || pos_reg == '0)
                        state_next = B_SEED_START;
                    else
                        state_next = B_GEN;
                end
            end
            B_SEED_START: state_next = B_SEED_WAIT;
            B_SEED_WAIT:  state_next = seed_rsp.done ? B_GEN : B_SEED_WAIT;
            B_GEN:        state_next = B_CONV;
            B_CONV:       state_next = B_PACK;
            B_PACK:       state_next = B_IDLE;
            default:      state_next = B_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        ctl = '0;
        case (state_reg)
            B_IDLE:       ctl.pop        = q_valid && !out_valid_reg;
            B_SEED_START: ctl.seed_start = 1'b1;
            B_SEED_WAIT:  ctl.load_seed  = seed_rsp.done;
            B_GEN:        ctl.gen        = 1'b1;
            B_CONV:       ctl.conv       = 1'b1;
            B_PACK:       ctl.pack       = 1'b1;
            default:      ctl            = '0;
        endcase
    end

    assign pop = ctl.pop;
    assign seed_req = '{start: ctl.seed_start, counter: subchunk_reg,
                        key_low: key_low, key_high: key_high};
    assign seed_zero = (seed_rsp.words == '0);

    // xoshiro256++ step
    assign sum    = wa_reg + wd_reg;
    assign rot    = {sum[40:0], sum[63:41]};
    assign r_next = rot + wa_reg;
    assign t      = {wb_reg[46:0], 17'd0};
    assign wc1    = wc_reg ^ wa_reg;
    assign wd1    = wd_reg ^ wb_reg;
    assign wb1    = wb_reg ^ wc1;
    assign wa1    = wa_reg ^ wd1;
    assign is_last = (pos_reg == POS_W'(SUBCHUNK_LEN - 1));

    // Conversion: locate the top set bit, then normalize
    assign v = {r_reg[63:12], 1'b1};
    always_comb
    begin
        p_next = 6'd0;
        for (int i = 0; i < 53; i++)
        begin
            if (v[i])
                p_next = 6'(i);
        end
    end
    assign v_reg_frac = v;
    assign v_shift    = v_reg_frac << (6'd52 - p_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            subchunk_reg  <= 64'd0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.pop && q_item.command == CMD_SEEK)
            begin
                subchunk_reg <= q_item.seek_subchunk;
                pos_reg      <= '0;
            end
            else if (ctl.gen)
            begin
                if (is_last)
                begin
                    pos_reg      <= '0;
                    subchunk_reg <= subchunk_reg + 64'd1;
                end
                else
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            if (ctl.pack)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_seed)
        begin
            wa_reg <= seed_zero ? 64'd1 : seed_rsp.words[0];
            wb_reg <= seed_rsp.words[1];
            wc_reg <= seed_rsp.words[2];
            wd_reg <= seed_rsp.words[3];
        end
        else if (ctl.gen)
        begin
            wa_reg   <= wa1;
            wb_reg   <= wb1;
            wc_reg   <= wc1 ^ t;
            wd_reg   <= {wd1[18:0], wd1[63:19]};
            r_reg    <= r_next;
            last_reg <= is_last;
        end
        if (ctl.conv)
            p_reg <= p_next;
        if (ctl.pack)
        begin
            out_raw_reg  <= r_reg;
            out_frac_reg <= v;
            out_bits_reg <= {1'b0, EXP_BASE + {5'd0, p_reg}, v_shift[51:0]};
            out_last_reg <= last_reg;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.raw_word         = out_raw_reg;
    assign out_ch.uniform_bits     = out_bits_reg;
    assign out_ch.uniform_fraction = out_frac_reg;
    assign out_ch.last_of_subchunk = out_last_reg;

endmodule

### hdl/philox_seeded_xoshiro_uniform.sv
// Top level of the Philox-seeded xoshiro256++ uniform generator.
// Depends on psx_pkg, psx_if, psx_front, psx_philox and psx_back.
//
// Usage:
//   in_ch  : one transaction per value wanted. command NEXT gives the next
//            value; command SEEK restarts at sub-chunk seek_subchunk and
//            gives its first value.
//   out_ch : one transaction per input, carrying the raw 64-bit word, the
//            double bit pattern of (m+0.5)*2^-52, its odd numerator 2m+1
//            and a flag on the last value of each 512-value sub-chunk.
//   cfg_ch : key writes, index 0 = key_low, index 1 = key_high; always
//            ready. A new key applies at the next reseed.
// Sequence: a value inside a sub-chunk passes the back-end steps issue,
//   xoshiro step, leading-one search and pack. The first value of a
//   sub-chunk, and any seek, adds a reseed through the Philox rounds, each
//   run as partial products, accumulates and an update on the single 32x32
//   partial-product multiplier per Philox product.
// A two-entry queue takes input while a result waits; when the receiver
//   stalls, the result register holds and the queue fills, then in_ch.ready
//   drops. Reset clears queue, position and sub-chunk index and restores
//   the default key; the first value then triggers a reseed.
module philox_seeded_xoshiro_uniform (
    input  logic       clk,
    input  logic       rst_n,
    psx_in_if.sink     in_ch,
    psx_out_if.source  out_ch,
    psx_cfg_if.sink    cfg_ch
);
    import psx_pkg::*;

    logic        q_valid;
    item_t       q_item;
    logic        pop;
    seed_req_t   seed_req;
    seed_rsp_t   seed_rsp;
    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;

    // Configuration: take every write at once
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= KEY_LOW_RESET;
            key_high_reg <= KEY_HIGH_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_KEY_LOW:  key_low_reg  <= cfg_ch.data;
                CFG_KEY_HIGH: key_high_reg <= cfg_ch.data;
                default:      key_low_reg  <= key_low_reg;
            endcase
        end
    end

    // Front: accept and queue transactions
    psx_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .pop     (pop),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    // Reseed unit
    psx_philox u_philox (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (seed_req),
        .rsp   (seed_rsp)
    );

    // Back: sequence, generate, convert, hold the result
    psx_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .key_low  (key_low_reg),
        .key_high (key_high_reg),
        .seed_req (seed_req),
        .seed_rsp (seed_rsp),
        .out_ch   (out_ch)
    );

endmodule

### hdl/psx_checker.sv
// Port-level checks on the result channel of the generator.
// Depends on nothing; bound to philox_seeded_xoshiro_uniform below.
module psx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] raw_word,
    input logic [63:0] uniform_bits,
    input logic [52:0] uniform_fraction
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(raw_word))
        else $error("stalled result dropped or changed");

    a_odd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> uniform_fraction[0] && uniform_fraction[52:1] == raw_word[63:12])
        else $error("fraction does not match raw word");

    a_top_exp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && uniform_fraction[52] |-> uniform_bits[63:52] == 12'h3fe)
        else $error("exponent wrong for top bit set");

    a_below_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !uniform_bits[63] && uniform_bits[62:52] < 11'h3ff)
        else $error("uniform value out of range");

endmodule

bind philox_seeded_xoshiro_uniform psx_checker u_psx_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .raw_word         (out_ch.raw_word),
    .uniform_bits     (out_ch.uniform_bits),
    .uniform_fraction (out_ch.uniform_fraction)
);

### bench/tb_psx_pkg.sv
// Bench-side constants for the uniform generator testbench.
// Depends on nothing; imported by the testbench top.
package tb_psx_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WAIT    = 18;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_TAIL  = 200;
endpackage

### bench/tb.sv
// Testbench top for philox_seeded_xoshiro_uniform: drives items and key writes,
// predicts every value and compares each result with the oldest prediction.
// Depends on psx_pkg, psx_if, tb_psx_pkg and philox_seeded_xoshiro_uniform.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psx_pkg::*;
    import tb_psx_pkg::*;

    typedef struct packed {
        logic [63:0] raw_word;
        logic [63:0] uniform_bits;
        logic [52:0] uniform_fraction;
        logic        last_of_subchunk;
    } value_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    psx_in_if  in_ch ();
    psx_out_if out_ch ();
    psx_cfg_if cfg_ch ();

    philox_seeded_xoshiro_uniform dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always #1 clk = ~clk;

    // Predictor state: key, xoshiro words, sub-chunk index and position.
    logic [63:0] key_lo, key_hi;
    logic [63:0] sa, sb, sc, sd;
    logic [63:0] chunk_idx;
    int unsigned chunk_pos;

    item_t  pending_items[$];
    value_t expected_values[$];
    int     errors = 0;
    int     results_seen = 0;
    int     in_flight = 0;
    longint cycles = 0;

    // Config writes requested by the stimulus, performed by the driver.
    logic        cfg_req = 1'b0;
    logic        cfg_req_index;
    logic [63:0] cfg_req_data;
    bit          cfg_ack = 1'b0;

    function automatic logic [127:0] mul128(logic [63:0] a, logic [63:0] b);
        return {64'd0, a} * {64'd0, b};
    endfunction

    // Refill the xoshiro words from Philox4x64 over {index,0,1,1}.
    task automatic philox_reseed();
        logic [63:0] c0, c1, c2, c3, k0, k1;
        logic [127:0] p0, p1;
        c0 = chunk_idx; c1 = 64'd0; c2 = 64'd1; c3 = 64'd1;
        k0 = key_lo; k1 = key_hi;
        for (int i = 0; i < PHILOX_ROUNDS; i++)
        begin
            if (i > 0)
            begin
                k0 = k0 + PX_BUMP0;
                k1 = k1 + PX_BUMP1;
            end
            p0 = mul128(PX_MUL0, c0);
            p1 = mul128(PX_MUL1, c2);
            c0 = p1[127:64] ^ c1 ^ k0;
            c1 = p1[63:0];
            c2 = p0[127:64] ^ c3 ^ k1;
            c3 = p0[63:0];
        end
        sa = c0; sb = c1; sc = c2; sd = c3;
        if ((sa | sb | sc | sd) == 64'd0)
            sa = 64'd1;
    endtask

    function automatic logic [63:0] to_double_bits(logic [52:0] v);
        int p;
        logic [63:0] w;
        p = 0;
        for (int i = 0; i < 53; i++)
            if (v[i])
                p = i;
        w = {11'd0, v} << (52 - p);
        return {1'b0, EXP_BASE + 11'(p), w[51:0]};
    endfunction

    // Advance the predictor by one item and queue the value it yields.
    task automatic predict_value(item_t it);
        logic [63:0] s, r, t;
        value_t ev;
        if (it.command == CMD_SEEK)
        begin
            chunk_idx = it.seek_subchunk;
            chunk_pos = 0;
        end
        if (chunk_pos == 0)
            philox_reseed();
        s = sa + sd;
        r = {s[40:0], s[63:41]} + sa;
        t = sb << 17;
        sc = sc ^ sa;
        sd = sd ^ sb;
        sb = sb ^ sc;
        sa = sa ^ sd;
        sc = sc ^ t;
        sd = {sd[18:0], sd[63:19]};
        ev.raw_word = r;
        ev.uniform_fraction = {r[63:12], 1'b1};
        ev.uniform_bits = to_double_bits(ev.uniform_fraction);
        chunk_pos++;
        ev.last_of_subchunk = (chunk_pos >= SUBCHUNK_LEN);
        if (ev.last_of_subchunk)
        begin
            chunk_pos = 0;
            chunk_idx = chunk_idx + 64'd1;
        end
        expected_values.push_back(ev);
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
    endtask

    // Driver: present queued items after a random gap per item.
    int in_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.command <= CMD_NEXT;
            in_ch.seek_subchunk <= 64'd0;
            in_gap = 0;
        end
        else if (in_ch.valid && !in_ch.ready)
        begin
            // hold the transaction
        end
        else
        begin
            if (in_ch.valid)
                predict_value(item_t'({in_ch.command, in_ch.seek_subchunk}));
            if (in_gap > 0 || pending_items.size() == 0)
            begin
                in_ch.valid <= 1'b0;
                if (in_gap > 0)
                    in_gap--;
            end
            else
            begin
                item_t it;
                it = pending_items.pop_front();
                in_flight++;
                in_ch.valid <= 1'b1;
                in_ch.command <= it.command;
                in_ch.seek_subchunk <= it.seek_subchunk;
                in_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, MAX_WAIT) : 0;
            end
        end
    end

    // Config driver: one write per request; the predictor takes it on accept.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.index <= CFG_KEY_LOW;
            cfg_ch.data <= 64'd0;
        end
        else if (cfg_ch.valid)
        begin
            if (cfg_ch.ready)
            begin
                if (cfg_ch.index == CFG_KEY_LOW)
                    key_lo = cfg_ch.data;
                else
                    key_hi = cfg_ch.data;
                cfg_ch.valid <= 1'b0;
                cfg_ack = 1'b1;
            end
        end
        else if (cfg_req && !cfg_ack)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= cfg_req_index;
            cfg_ch.data <= cfg_req_data;
        end
    end

    // Monitor: random receiver stalls, compare each accepted result.
    int out_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            cycles++;
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                in_flight--;
                if (expected_values.size() == 0)
                begin
                    errors++;
                    $display("unexpected result %h", out_ch.raw_word);
                end
                else
                begin
                    value_t ev;
                    ev = expected_values.pop_front();
                    if (out_ch.raw_word !== ev.raw_word)
                        report("raw_word", out_ch.raw_word, ev.raw_word);
                    if (out_ch.uniform_bits !== ev.uniform_bits)
                        report("uniform_bits", out_ch.uniform_bits, ev.uniform_bits);
                    if (out_ch.uniform_fraction !== ev.uniform_fraction)
                        report("uniform_fraction", 64'(out_ch.uniform_fraction),
                               64'(ev.uniform_fraction));
                    if (out_ch.last_of_subchunk !== ev.last_of_subchunk)
                        report("last_of_subchunk", 64'(out_ch.last_of_subchunk),
                               64'(ev.last_of_subchunk));
                end
                out_gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (out_gap > 0)
            begin
                out_ch.ready <= 1'b0;
                out_gap--;
            end
            else
                out_ch.ready <= 1'b1;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Wait until the block is idle: nothing pending, nothing in flight.
    task automatic wait_idle();
        while (pending_items.size() != 0 || in_flight > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_key(logic idx, logic [63:0] val);
        @(posedge clk);
        cfg_req_index = idx;
        cfg_req_data = val;
        cfg_ack = 1'b0;
        cfg_req = 1'b1;
        while (!cfg_ack)
            @(posedge clk);
        cfg_req = 1'b0;
        @(posedge clk);
    endtask

    task automatic add_item(logic cmd, logic [63:0] idx);
        pending_items.push_back(item_t'({cmd, idx}));
    endtask

    initial
    begin
        key_lo = KEY_LOW_RESET;
        key_hi = KEY_HIGH_RESET;
        sa = 0; sb = 0; sc = 0; sd = 0;
        chunk_idx = 0;
        chunk_pos = 0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_NEXT;
        in_ch.seek_subchunk = 64'd0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_KEY_LOW;
        cfg_ch.data = 64'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: first value after reset on the default key, seeks to
        // the index extremes, and a NEXT after the seek to index 2^64-1.
        add_item(CMD_NEXT, 64'd0);
        add_item(CMD_NEXT, rand64());
        add_item(CMD_SEEK, 64'd0);
        add_item(CMD_SEEK, 64'hFFFF_FFFF_FFFF_FFFF);
        add_item(CMD_NEXT, 64'd0);
        add_item(CMD_SEEK, 64'h5555_5555_5555_5555);
        add_item(CMD_SEEK, 64'hAAAA_AAAA_AAAA_AAAA);
        wait_idle();

        // Key extremes, then a full sub-chunk crossing the wrap.
        write_key(CFG_KEY_LOW, 64'd0);
        write_key(CFG_KEY_HIGH, 64'd0);
        add_item(CMD_SEEK, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < SUBCHUNK_LEN + 3; i++)
            add_item(CMD_NEXT, rand64());
        wait_idle();
        write_key(CFG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_key(CFG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        add_item(CMD_SEEK, 64'd7);
        add_item(CMD_NEXT, 64'd0);
        // Key change mid sub-chunk applies only at the next reseed.
        wait_idle();
        write_key(CFG_KEY_LOW, rand64());
        write_key(CFG_KEY_HIGH, rand64());
        add_item(CMD_NEXT, 64'd0);
        add_item(CMD_SEEK, 64'd8);

        // Short random phases: mostly NEXT, occasional seeks to random indices or near the index extremes.
        for (int ph = 0; ph < 2; ph++)
        begin
            wait_idle();
            write_key(CFG_KEY_LOW, rand64());
            write_key(CFG_KEY_HIGH, rand64());
            for (int i = 0; i < 20; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_item(CMD_SEEK, $urandom_range(0, 1) ? rand64()
                                       : 64'($urandom_range(0, 3)) - 64'd2);
                else
                    add_item(CMD_NEXT, rand64());
            end
        end
        while (pending_items.size() != 0 || in_flight > 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
        $display("covered %0d results: seeks, sub-chunk ends, index wrap, key extremes",
                 results_seen);
        if (errors == 0 && expected_values.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### philox_seeded_xoshiro_uniform.f
hdl/psx_pkg.sv
hdl/psx_if.sv
hdl/psx_front.sv
hdl/psx_philox.sv
hdl/psx_back.sv
hdl/philox_seeded_xoshiro_uniform.sv
hdl/psx_checker.sv
bench/tb_psx_pkg.sv
bench/tb.sv
